### hdl/itce_pkg.sv
package itce_pkg;

  // Default limit on frame length; bytes at and past it are ignored
  localparam int MAX_FRAME_BYTES_DEF = 16384;

  // Stream widths
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 3;

  // word_bytes code for a word whose lower byte is not part of the frame
  localparam logic [1:0] WB_UPPER_ONLY = 2'd1;

  // Frame layout, byte offsets
  localparam int ETH_HDR_BYTES    = 14;
  localparam int IP_MIN_HDR_BYTES = 20;
  localparam int UDP_HDR_BYTES    = 8;

  // Offsets inside the IPv4 header
  localparam int IP_TLEN_HI   = 2;
  localparam int IP_TLEN_LO   = 3;
  localparam int IP_PROTO     = 9;
  localparam int IP_CSUM_HI   = 10;
  localparam int IP_CSUM_LO   = 11;
  localparam int IP_ADDR_LO   = 12;
  localparam int IP_ADDR_END  = 20;

  // Offsets inside the L4 header
  localparam int TCP_DOFF     = 12;
  localparam int TCP_CSUM_HI  = 16;
  localparam int TCP_CSUM_LO  = 17;
  localparam int UDP_CSUM_HI  = 6;
  localparam int UDP_CSUM_LO  = 7;

  // Protocol numbers and version
  localparam logic [7:0] TCP_PROTO_NUM = 8'd6;
  localparam logic [7:0] UDP_PROTO_NUM = 8'd17;
  localparam logic [3:0] IP_VERSION    = 4'd4;

  typedef enum logic [1:0] {
    L4_OTHER = 2'd0,
    L4_TCP   = 2'd1,
    L4_UDP   = 2'd2
  } l4_kind_t;

  // Per-frame totals handed from the accumulator to the finishing stage
  typedef struct packed {
    logic [31:0] ip_sum;
    logic [31:0] l4_sum;
    logic [3:0]  hdr_words;
    logic        version_ok;
    logic [7:0]  protocol;
    logic [15:0] total_len;
    logic [3:0]  tcp_off;
  } tot_t;

endpackage

### hdl/itce_accum.sv
module itce_accum #(
  parameter int MAX_FRAME_BYTES = itce_pkg::MAX_FRAME_BYTES_DEF,
  parameter int PW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [15:0] frame_word, [17:16] word_bytes, [23:18] zero
  input  logic [itce_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  output logic                         tot_valid,
  input  logic                         tot_ready,
  output itce_pkg::tot_t               tot,
  output logic [PW-1:0]                tot_pos
);

  typedef struct packed {
    logic [PW-1:0]  pos;
    itce_pkg::tot_t t;
  } acc_t;

  logic        a_valid;
  logic [15:0] a_word;
  logic [1:0]  a_bytes;
  logic        a_last;
  logic        a_go;
  logic        b_free;
  acc_t        acc;
  acc_t        acc_mid;
  acc_t        acc_next;

  // Fold one frame byte into the running state
  function automatic acc_t take_byte(acc_t s, logic [7:0] b);
    acc_t          n;
    logic [15:0]   w;
    logic [PW-1:0] r;
    logic [PW-1:0] q;
    logic [5:0]    hl;
    n  = s;
    w  = '0;
    r  = '0;
    q  = '0;
    hl = '0;
    if (s.pos < PW'(MAX_FRAME_BYTES)) begin
      n.pos = s.pos + 1'b1;
      w = s.pos[0] ? {8'h00, b} : {b, 8'h00};
      if (s.pos == PW'(itce_pkg::ETH_HDR_BYTES)) begin
        n.t.version_ok = (b[7:4] == itce_pkg::IP_VERSION);
        n.t.hdr_words  = b[3:0];
      end
      if (s.pos >= PW'(itce_pkg::ETH_HDR_BYTES) && n.t.version_ok) begin
        r = s.pos - PW'(itce_pkg::ETH_HDR_BYTES);
        if (r == PW'(itce_pkg::IP_TLEN_HI)) begin
          n.t.total_len[15:8] = b;
        end else if (r == PW'(itce_pkg::IP_TLEN_LO)) begin
          n.t.total_len[7:0] = b;
        end else if (r == PW'(itce_pkg::IP_PROTO)) begin
          n.t.protocol = b;
        end
        hl = {n.t.hdr_words, 2'b00};
        // IP header sum, checksum field taken as zero
        if (32'(r) < 32'(hl) && r != PW'(itce_pkg::IP_CSUM_HI)
            && r != PW'(itce_pkg::IP_CSUM_LO)) begin
          n.t.ip_sum = n.t.ip_sum + 32'(w);
        end
        // Source and destination addresses go into the pseudo header
        if (r >= PW'(itce_pkg::IP_ADDR_LO) && r < PW'(itce_pkg::IP_ADDR_END)) begin
          n.t.l4_sum = n.t.l4_sum + 32'(w);
        end
        // L4 bytes, from the end of the IP options up to total length
        if (hl >= 6'(itce_pkg::IP_MIN_HDR_BYTES) && 32'(r) >= 32'(hl)
            && 32'(r) < 32'(n.t.total_len)) begin
          q = r - PW'(hl);
          if (n.t.protocol == itce_pkg::TCP_PROTO_NUM) begin
            if (q == PW'(itce_pkg::TCP_DOFF)) begin
              n.t.tcp_off = b[7:4];
            end
            if (q != PW'(itce_pkg::TCP_CSUM_HI) && q != PW'(itce_pkg::TCP_CSUM_LO)) begin
              n.t.l4_sum = n.t.l4_sum + 32'(w);
            end
          end else if (n.t.protocol == itce_pkg::UDP_PROTO_NUM) begin
            if (q != PW'(itce_pkg::UDP_CSUM_HI) && q != PW'(itce_pkg::UDP_CSUM_LO)) begin
              n.t.l4_sum = n.t.l4_sum + 32'(w);
            end
          end
        end
      end
    end
    return n;
  endfunction

  // Handshake: a word that ends a frame waits for the totals register
  assign b_free   = !tot_valid || tot_ready;
  assign a_go     = a_valid && (!a_last || b_free);
  assign s_tready = !a_valid || a_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= (s_tvalid && s_tready) || (a_valid && !a_go);
    end
    if (s_tvalid && s_tready) begin
      a_word  <= s_tdata[15:0];
      a_bytes <= s_tdata[17:16];
      a_last  <= s_tlast;
    end
  end

  // Upper byte first, then the lower byte when present
  always_comb begin
    acc_mid  = take_byte(acc, a_word[15:8]);
    acc_next = (a_bytes != itce_pkg::WB_UPPER_ONLY) ? take_byte(acc_mid, a_word[7:0])
                                                    : acc_mid;
  end

  // Running state; clear it once a frame's totals are handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (a_go) begin
      acc <= a_last ? '0 : acc_next;
    end
  end

  // Totals register
  always_ff @(posedge clk) begin
    if (rst) begin
      tot_valid <= 1'b0;
    end else begin
      tot_valid <= (tot_valid && !tot_ready) || (a_go && a_last);
    end
    if (a_go && a_last) begin
      tot     <= acc_next.t;
      tot_pos <= acc_next.pos;
    end
  end

endmodule

### hdl/itce_finish.sv
module itce_finish #(
  parameter int MAX_FRAME_BYTES = itce_pkg::MAX_FRAME_BYTES_DEF,
  parameter int PW = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tot_valid,
  output logic                           tot_ready,
  input  itce_pkg::tot_t                 tot,
  input  logic [PW-1:0]                  tot_pos,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] ip_checksum, [31:16] l4_checksum, [37:32] ip_header_bytes,
  // [43:38] l4_header_bytes, [44] truncated, [47:45] zero
  output logic [itce_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] is_ipv4, [2:1] l4_kind
  output logic [itce_pkg::M_TUSER_W-1:0] m_tuser
);

  logic [5:0]         hl;
  logic [15:0]        ip_fold;
  logic [15:0]        ip_csum;
  logic [31:0]        l4_total;
  logic [15:0]        l4_fold;
  logic [15:0]        l4_csum;
  logic [5:0]         l4_hdr;
  itce_pkg::l4_kind_t kind;
  logic [15:0]        need;
  logic               trunc;
  logic               is_ipv4;
  logic [5:0]         ip_hdr;

  // Ones' complement fold of a 32-bit sum
  function automatic logic [15:0] fold16(logic [31:0] s);
    logic [16:0] s1;
    s1 = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    return s1[15:0] + {15'd0, s1[16]};
  endfunction

  always_comb begin
    hl      = {tot.hdr_words, 2'b00};
    is_ipv4 = tot.version_ok;
    ip_hdr  = is_ipv4 ? hl : '0;

    // IP header checksum; a folded sum of all ones stays as it is
    ip_fold = fold16(tot.ip_sum);
    ip_csum = '0;
    if (is_ipv4) begin
      ip_csum = (ip_fold == 16'hffff) ? ip_fold : ~ip_fold;
    end

    // Classify, dropping malformed lengths
    kind = itce_pkg::L4_OTHER;
    if (is_ipv4 && hl >= 6'(itce_pkg::IP_MIN_HDR_BYTES) && tot.total_len >= 16'(hl)) begin
      if (tot.protocol == itce_pkg::TCP_PROTO_NUM) begin
        kind = itce_pkg::L4_TCP;
      end else if (tot.protocol == itce_pkg::UDP_PROTO_NUM) begin
        kind = itce_pkg::L4_UDP;
      end
    end

    // Add protocol and L4 length from the pseudo header, then fold
    l4_total = tot.l4_sum + 32'(tot.protocol) + 32'(tot.total_len - 16'(hl));
    l4_fold  = fold16(l4_total);
    l4_csum  = '0;
    l4_hdr   = '0;
    unique case (kind)
      itce_pkg::L4_TCP: begin
        l4_csum = ~l4_fold;
        l4_hdr  = {tot.tcp_off, 2'b00};
      end
      itce_pkg::L4_UDP: begin
        l4_csum = (~l4_fold == 16'h0000) ? 16'hffff : ~l4_fold;
        l4_hdr  = 6'(itce_pkg::UDP_HDR_BYTES);
      end
      default: begin
        l4_csum = '0;
        l4_hdr  = '0;
      end
    endcase

    // Bytes needed: Ethernet header plus the largest of the IP lengths
    need = 16'(itce_pkg::IP_MIN_HDR_BYTES);
    if (16'(hl) > need) begin
      need = 16'(hl);
    end
    if (tot.total_len > need) begin
      need = tot.total_len;
    end
    if (is_ipv4) begin
      trunc = 32'(tot_pos) < (32'(need) + 32'(itce_pkg::ETH_HDR_BYTES));
    end else begin
      trunc = 32'(tot_pos) < 32'(itce_pkg::ETH_HDR_BYTES + 1);
    end
  end

  assign tot_ready = !m_tvalid || m_tready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tot_ready) begin
      m_tvalid <= tot_valid;
    end
    if (tot_valid && tot_ready) begin
      m_tdata <= {3'b000, trunc, l4_hdr, ip_hdr, l4_csum, ip_csum};
      m_tuser <= {kind, is_ipv4};
    end
  end

endmodule

### hdl/ipv4_tcp_udp_checksum_engine_unit.sv
// IPv4 / TCP / UDP checksum engine. Frames enter as 16-bit words in network
// order (Ethernet header without VLAN tag first, first byte in the upper half);
// word_bytes of 1 marks a word with only its upper byte valid. One word is
// taken every clock unless an end-of-frame word waits for the totals register,
// and one result leaves per tlast word through the input register, running-sum
// update with the per-frame state into the totals register, and the folding
// stage into the result register. The result gives the IPv4 header checksum,
// the TCP or UDP checksum over the pseudo header and segment (zero for other
// protocols), both header lengths and a flag for frames that end before the
// header or total length is complete. Bytes past total length are ignored, as
// are bytes at and beyond MAX_FRAME_BYTES. A held result stalls input only once
// a further end-of-frame word has to wait behind it.
module ipv4_tcp_udp_checksum_engine_unit #(
  parameter int MAX_FRAME_BYTES = itce_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] frame_word, [17:16] word_bytes, [23:18] zero
  input  logic [itce_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] ip_checksum, [31:16] l4_checksum, [37:32] ip_header_bytes,
  // [43:38] l4_header_bytes, [44] truncated, [47:45] zero
  output logic [itce_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] is_ipv4, [2:1] l4_kind
  output logic [itce_pkg::M_TUSER_W-1:0] m_tuser
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

  logic           tot_valid;
  logic           tot_ready;
  itce_pkg::tot_t tot;
  logic [PW-1:0]  tot_pos;

  // Accumulate sums and header fields per frame
  itce_accum #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .PW(PW)
  ) u_accum (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .tot_valid(tot_valid),
    .tot_ready(tot_ready),
    .tot(tot),
    .tot_pos(tot_pos)
  );

  // Fold, classify and register the result
  itce_finish #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .PW(PW)
  ) u_finish (
    .clk(clk),
    .rst(rst),
    .tot_valid(tot_valid),
    .tot_ready(tot_ready),
    .tot(tot),
    .tot_pos(tot_pos),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

endmodule

### tb/sv/itce_checksum_monitor.sv
`timescale 1ns / 1ps

module itce_checksum_monitor
  import itce_pkg::*;
#(
  parameter int FRAME_LIMIT = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // [15:0] frame_word, [17:16] word_bytes, [23:18] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // [15:0] ip_checksum, [31:16] l4_checksum, [37:32] ip_header_bytes,
  // [43:38] l4_header_bytes, [44] truncated, [47:45] zero
  input  logic [M_TDATA_W-1:0] m_tdata,
  // [0] is_ipv4, [2:1] l4_kind
  input  logic [M_TUSER_W-1:0] m_tuser,
  output int                   fail_total,
  output int                   sums_outstanding
);

  localparam int         MAX_REPORTS   = 40;

  typedef struct packed {
    logic        is_ipv4;
    l4_kind_t    kind;
    logic [15:0] ip_csum;
    logic [15:0] l4_csum;
    logic [5:0]  ip_hlen;
    logic [5:0]  l4_hlen;
    logic        trunc;
  } frame_sums_t;

  // Per-frame running state of the predictor
  int unsigned byte_pos;
  logic [31:0] ip_acc;
  logic [31:0] l4_acc;
  logic [3:0]  ihl_q;
  logic        ver_ok;
  logic [7:0]  proto_q;
  logic [15:0] tot_len;
  logic [3:0]  doff_q;

  frame_sums_t pending_sums[$];
  frame_sums_t want;

  initial fail_total = 0;
  initial sums_outstanding = 0;

  function automatic void clear_frame();
    byte_pos = 0;
    ip_acc   = '0;
    l4_acc   = '0;
    ihl_q    = '0;
    ver_ok   = 1'b0;
    proto_q  = '0;
    tot_len  = '0;
    doff_q   = '0;
  endfunction

  function automatic logic [15:0] fold_carries(input logic [31:0] s);
    logic [31:0] acc;
    acc = s;
    while (acc[31:16] != 16'd0) acc = acc[31:16] + acc[15:0];
    return acc[15:0];
  endfunction

  // Fold one frame byte into the header and segment sums
  function automatic void absorb_byte(input logic [7:0] b);
    int unsigned p, r, hl, q;
    logic [31:0] w;
    p = byte_pos;
    if (p >= FRAME_LIMIT) return;
    byte_pos = p + 1;
    w = p[0] ? {24'd0, b} : {16'd0, b, 8'd0};
    if (p == ETH_HDR_BYTES) begin
      ver_ok = (b[7:4] == IP_VERSION);
      ihl_q  = b[3:0];
    end
    if (p < ETH_HDR_BYTES || !ver_ok) return;

    r = p - ETH_HDR_BYTES;
    if (r == IP_TLEN_HI) tot_len[15:8] = b;
    else if (r == IP_TLEN_LO) tot_len[7:0] = b;
    else if (r == IP_PROTO) proto_q = b;

    hl = ihl_q * 4;
    if (r < hl && r != IP_CSUM_HI && r != IP_CSUM_LO) ip_acc += w;
    // addresses enter the pseudo header
    if (r >= IP_ADDR_LO && r < IP_ADDR_END) l4_acc += w;

    if (hl >= IP_MIN_HDR_BYTES && r >= hl && r < tot_len) begin
      q = r - hl;
      if (proto_q == TCP_PROTO_NUM) begin
        if (q == TCP_DOFF) doff_q = b[7:4];
        if (q != TCP_CSUM_HI && q != TCP_CSUM_LO) l4_acc += w;
      end else if (proto_q == UDP_PROTO_NUM) begin
        if (q != UDP_CSUM_HI && q != UDP_CSUM_LO) l4_acc += w;
      end
    end
  endfunction

  // Finish the frame: work out every result field, then clear the state
  function automatic frame_sums_t close_frame();
    frame_sums_t res;
    logic [15:0] f;
    int unsigned hl, tl, need;
    res = '0;
    hl = ihl_q * 4;
    tl = tot_len;
    if (ver_ok) begin
      res.is_ipv4 = 1'b1;
      f = fold_carries(ip_acc);
      res.ip_csum = (f == 16'hffff) ? f : ~f;
      res.ip_hlen = 6'(hl);
      if (hl >= IP_MIN_HDR_BYTES && tl >= hl) begin
        if (proto_q == TCP_PROTO_NUM) res.kind = L4_TCP;
        else if (proto_q == UDP_PROTO_NUM) res.kind = L4_UDP;
      end
      if (res.kind != L4_OTHER) begin
        f = fold_carries(l4_acc + proto_q + (tl - hl));
        res.l4_csum = ~f;
        // a zero UDP checksum means no checksum, so send all ones instead
        if (res.kind == L4_UDP && res.l4_csum == 16'd0) res.l4_csum = 16'hffff;
        res.l4_hlen = (res.kind == L4_TCP) ? {doff_q, 2'b00} : 6'(UDP_HDR_BYTES);
      end
      need = IP_MIN_HDR_BYTES;
      if (hl > need) need = hl;
      if (tl > need) need = tl;
      res.trunc = (byte_pos < ETH_HDR_BYTES + need);
    end else begin
      res.trunc = (byte_pos < ETH_HDR_BYTES + 1);
    end
    clear_frame();
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input logic [15:0] got_v,
                               input logic [15:0] exp_v);
    if (fail_total < MAX_REPORTS)
      $display("%0t: %s got %h, wanted %h", $time, field, got_v, exp_v);
    fail_total++;
  endtask

  // Check results leaving the block, then predict from requests entering it
  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      pending_sums.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_sums.size() == 0) begin
          flag_mismatch("result with no frame pending", m_tdata[15:0], 16'd0);
        end else begin
          want = pending_sums.pop_front();
          if (m_tuser[0] !== want.is_ipv4)
            flag_mismatch("is_ipv4", 16'(m_tuser[0]), 16'(want.is_ipv4));
          if (m_tuser[2:1] !== want.kind)
            flag_mismatch("l4_kind", 16'(m_tuser[2:1]), 16'(want.kind));
          if (m_tdata[15:0] !== want.ip_csum)
            flag_mismatch("ip_checksum", m_tdata[15:0], want.ip_csum);
          if (m_tdata[31:16] !== want.l4_csum)
            flag_mismatch("l4_checksum", m_tdata[31:16], want.l4_csum);
          if (m_tdata[37:32] !== want.ip_hlen)
            flag_mismatch("ip_header_bytes", 16'(m_tdata[37:32]), 16'(want.ip_hlen));
          if (m_tdata[43:38] !== want.l4_hlen)
            flag_mismatch("l4_header_bytes", 16'(m_tdata[43:38]), 16'(want.l4_hlen));
          if (m_tdata[44] !== want.trunc)
            flag_mismatch("truncated", 16'(m_tdata[44]), 16'(want.trunc));
        end
      end
      if (s_tvalid && s_tready) begin
        absorb_byte(s_tdata[15:8]);
        if (s_tdata[17:16] != WB_UPPER_ONLY) absorb_byte(s_tdata[7:0]);
        if (s_tlast) pending_sums.push_back(close_frame());
      end
    end
    sums_outstanding = pending_sums.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import itce_pkg::*;

  localparam int FRAME_LIMIT   = MAX_FRAME_BYTES_DEF;
  localparam int RANDOM_WORDS  = 1750;
  localparam int RANDOM_FRAMES = 40;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 600;
  localparam int HOLD_PERIOD   = 3000;
  localparam longint RUN_LIMIT_NS = 64'd400_000 * 12;

  // word_bytes codes
  localparam logic [1:0] WB_NONE_SET   = 2'd0;
  localparam logic [1:0] WB_BOTH       = 2'd2;
  localparam logic [1:0] WB_ALL_SET    = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  int                   fail_total;
  int                   sums_outstanding;

  logic [7:0] frame_buf[$];
  int         words_sent;
  int         frames_sent;

  ipv4_tcp_udp_checksum_engine_unit #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  itce_checksum_monitor #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_monitor (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .fail_total      (fail_total),
    .sums_outstanding(sums_outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Build an Ethernet + IPv4 frame with a random body in frame_buf
  function automatic void make_ip(input int ihl, input logic [15:0] tl_field,
                                  input logic [7:0] proto, input int doff,
                                  input int l4_bytes, input int pad);
    int hdr, l4_at;
    frame_buf.delete();
    repeat (12) frame_buf.push_back(rand_byte());
    frame_buf.push_back(8'h08);
    frame_buf.push_back(8'h00);
    frame_buf.push_back({IP_VERSION, 4'(ihl)});
    frame_buf.push_back(rand_byte());
    frame_buf.push_back(tl_field[15:8]);
    frame_buf.push_back(tl_field[7:0]);
    // identification, flags, ttl
    repeat (5) frame_buf.push_back(rand_byte());
    frame_buf.push_back(proto);
    // header checksum and both addresses
    repeat (10) frame_buf.push_back(rand_byte());
    hdr = (ihl > 5) ? ihl * 4 : IP_MIN_HDR_BYTES;
    repeat (hdr - IP_MIN_HDR_BYTES) frame_buf.push_back(rand_byte());
    l4_at = frame_buf.size();
    repeat (l4_bytes) frame_buf.push_back(rand_byte());
    if (proto == TCP_PROTO_NUM && l4_bytes > TCP_DOFF)
      frame_buf[l4_at+TCP_DOFF] = {4'(doff), frame_buf[l4_at+TCP_DOFF][3:0]};
    if (proto == UDP_PROTO_NUM && l4_bytes >= 6) begin
      frame_buf[l4_at+4] = 8'(l4_bytes >> 8);
      frame_buf[l4_at+5] = 8'(l4_bytes);
    end
    repeat (pad) frame_buf.push_back(rand_byte());
  endfunction

  // Ones' complement sum of the even-aligned words in frame_buf[lo..hi-1]
  function automatic logic [15:0] span_fold(input int lo, input int hi,
                                            input logic [31:0] extra);
    logic [31:0] s;
    s = extra;
    for (int i = lo; i < hi; i += 2) s += {frame_buf[i], frame_buf[i+1]};
    while (s[31:16] != 16'd0) s = s[31:16] + s[15:0];
    return s[15:0];
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise
  function automatic void make_random_frame();
    int r, ihl, doff, payload, l4n, pad, tl, v;
    logic [7:0] proto;
    r = $urandom_range(0, 99);
    if (r >= 96) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 90)) frame_buf.push_back(rand_byte());
      return;
    end
    ihl = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(5, 15);
    case ($urandom_range(0, 4))
      0, 1:    proto = TCP_PROTO_NUM;
      2, 3:    proto = UDP_PROTO_NUM;
      default: proto = rand_byte();
    endcase
    doff = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
    payload = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 24) : $urandom_range(25, 160);
    if (proto == TCP_PROTO_NUM) l4n = doff * 4 + payload;
    else if (proto == UDP_PROTO_NUM) l4n = UDP_HDR_BYTES + payload;
    else l4n = payload;
    pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    // odd total lengths, short segments and lengths below the header
    if (r >= 80 && r < 86) tl = $urandom_range(0, ihl * 4 + 16);
    else tl = ihl * 4 + l4n;
    if (r >= 86 && r < 91) ihl = $urandom_range(0, 4);
    make_ip(ihl, 16'(tl), proto, doff, l4n, pad);
    if (r >= 72 && r < 80) frame_buf = frame_buf[0:$urandom_range(0, frame_buf.size() - 2)];
    if (r >= 91) begin
      v = $urandom_range(0, 14);
      if (v >= IP_VERSION) v++;
      frame_buf[ETH_HDR_BYTES] = {4'(v), frame_buf[ETH_HDR_BYTES][3:0]};
    end
  endfunction

  // Stream frame_buf as words; optionally gap between words and split bytes
  task automatic send_frame(input bit gaps_on, input bit splits_on);
    int idx, gap, r;
    logic [15:0] word;
    logic [1:0] wb;
    idx = 0;
    while (idx < frame_buf.size()) begin
      if (frame_buf.size() - idx == 1 || (splits_on && $urandom_range(0, 49) == 0)) begin
        word = {frame_buf[idx], rand_byte()};
        wb = WB_UPPER_ONLY;
        idx += 1;
      end else begin
        word = {frame_buf[idx], frame_buf[idx+1]};
        r = $urandom_range(0, 19);
        wb = (r == 0) ? WB_NONE_SET : (r == 1) ? WB_ALL_SET : WB_BOTH;
        idx += 2;
      end
      gap = 0;
      if (gaps_on) begin
        r = $urandom_range(0, 99);
        if (r >= 94) gap = $urandom_range(6, 12);
        else if (r >= 70) gap = $urandom_range(1, 3);
      end
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      @(negedge clk);
      s_tvalid <= 1'b1;
      s_tdata  <= {6'd0, wb, word};
      s_tlast  <= (idx >= frame_buf.size());
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      words_sent++;
    end
    frames_sent++;
  endtask

  // Result side: random stalls, calm stretches and a periodic long hold-off
  initial begin
    int rx_cycles, stall_left, r;
    bit calm;
    m_tready = 1'b0;
    rx_cycles = 0;
    stall_left = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 600 == 0) calm = ($urandom_range(0, 2) == 0);
      if (rx_cycles % HOLD_PERIOD == 1000) begin
        // hold off long enough for finished frames to back up into the input
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r >= 92) stall_left = $urandom_range(8, 30);
          else if (r >= 65) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // Hard stop for a hung block
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    logic [15:0] w;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    words_sent = 0;
    frames_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // TCP with the shortest headers and no payload
    make_ip(5, 40, TCP_PROTO_NUM, 5, 20, 0);
    send_frame(1, 0);
    // longest IP options and TCP header, odd length so the last word is half full
    make_ip(15, 127, TCP_PROTO_NUM, 15, 67, 0);
    send_frame(1, 0);
    // UDP checksum that comes out as zero and is sent as all ones
    make_ip(5, 30, UDP_PROTO_NUM, 0, 10, 0);
    for (int i = 40; i < 44; i++) frame_buf[i] = 8'd0;
    w = ~span_fold(26, 44, 32'(UDP_PROTO_NUM) + 32'd10);
    frame_buf[42] = w[15:8];
    frame_buf[43] = w[7:0];
    send_frame(1, 0);
    // header sum that folds to all ones and is sent unchanged
    make_ip(5, 28, UDP_PROTO_NUM, 0, 8, 0);
    frame_buf[18] = 8'd0;
    frame_buf[19] = 8'd0;
    frame_buf[24] = 8'd0;
    frame_buf[25] = 8'd0;
    w = ~span_fold(14, 34, 32'd0);
    frame_buf[18] = w[15:8];
    frame_buf[19] = w[7:0];
    send_frame(1, 0);
    // protocol that is neither TCP nor UDP
    make_ip(6, 36, 8'd1, 0, 12, 0);
    send_frame(1, 0);
    // all-ones header with the largest total length, frame falls short
    make_ip(15, 16'hffff, 8'hff, 0, 40, 0);
    for (int i = ETH_HDR_BYTES + 1; i < frame_buf.size(); i++) frame_buf[i] = 8'hff;
    send_frame(1, 0);
    // not version four
    make_ip(5, 60, TCP_PROTO_NUM, 5, 40, 0);
    frame_buf[ETH_HDR_BYTES] = {4'd6, 4'd5};
    send_frame(1, 0);
    // frames that end before the version byte
    make_ip(5, 40, TCP_PROTO_NUM, 5, 20, 0);
    frame_buf = frame_buf[0:ETH_HDR_BYTES-1];
    send_frame(1, 0);
    frame_buf = frame_buf[0:0];
    send_frame(1, 0);
    // header length below the minimum
    make_ip(3, 40, TCP_PROTO_NUM, 5, 20, 0);
    send_frame(1, 0);
    make_ip(0, 40, UDP_PROTO_NUM, 0, 20, 0);
    send_frame(1, 0);
    // total length shorter than the header
    make_ip(5, 10, UDP_PROTO_NUM, 0, 8, 0);
    send_frame(1, 0);
    // TCP segment that stops before the data offset byte
    make_ip(5, 32, TCP_PROTO_NUM, 5, 12, 0);
    send_frame(1, 0);
    // padding past total length
    make_ip(5, 36, UDP_PROTO_NUM, 0, 16, 11);
    send_frame(1, 0);
    // frame cut off inside the TCP header
    make_ip(5, 60, TCP_PROTO_NUM, 8, 40, 0);
    frame_buf = frame_buf[0:44];
    send_frame(1, 0);
    // all-zero frame
    frame_buf.delete();
    repeat (60) frame_buf.push_back(8'd0);
    send_frame(1, 0);

    // random frames
    while (words_sent < RANDOM_WORDS || frames_sent < RANDOM_FRAMES) begin
      make_random_frame();
      send_frame($urandom_range(0, 9) < 7, $urandom_range(0, 9) < 3);
    end

    // drain and give the verdict
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sums_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_total == 0 && sums_outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hdl/itce_pkg.sv
hdl/itce_accum.sv
hdl/itce_finish.sv
hdl/ipv4_tcp_udp_checksum_engine_unit.sv
tb/sv/itce_checksum_monitor.sv
tb/sv/tb.sv
